[rtl/spq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared constants, codes and the command struct that the top level hands to
// every storage cell of the chain.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int VALUE_W          = 32;
    localparam int STATUS_W         = 2;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Broadcast to every cell in the cycle a transaction is accepted.
    typedef struct packed {
        logic                       insert_en;
        logic                       remove_en;
        logic signed [VALUE_W-1:0]  new_value;
    } cell_cmd_t;

endpackage
`default_nettype wire

[rtl/spq_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue storage cell
// Holds one value of the ascending chain. On insert it keeps its value, takes
// the new value or takes its left neighbour's value; on remove it takes its
// right neighbour's value.
// ----------------------------------------------------------------------------
module spq_cell
(
    input  wire                              clk,
    input  wire spq_pkg::cell_cmd_t          cmd,
    input  wire                              occupied,
    input  wire                              left_gt,
    input  wire logic signed [spq_pkg::VALUE_W-1:0] left_value,
    input  wire logic signed [spq_pkg::VALUE_W-1:0] right_value,
    output logic signed [spq_pkg::VALUE_W-1:0]      value,
    output logic                             gt
);

    logic signed [spq_pkg::VALUE_W-1:0] value_reg;
    logic signed [spq_pkg::VALUE_W-1:0] value_next;

    // A stored value greater than the new one must move one place right, so
    // equal values stay ahead of the newcomer.
    assign gt = occupied && (value_reg > cmd.new_value);

    always_comb
    begin
        value_next = value_reg;
        if (cmd.remove_en)
        begin
            value_next = right_value;
        end
        else if (cmd.insert_en)
        begin
            if (left_gt)
            begin
                value_next = left_value;
            end
            else if (!occupied || gt)
            begin
                value_next = cmd.new_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule
`default_nettype wire

[rtl/sorted_priority_queue_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue unit
// Keeps up to CAPACITY signed values in ascending order in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one operation per transaction: s_tuser selects
// insert (0) or remove-smallest (1) and s_tdata carries the value to insert.
// Every accepted transaction produces exactly one result transaction on the
// master channel carrying a status, the removed value and the occupancy
// after the operation. Equal values leave in arrival order.
// m_tvalid rises in the cycle after acceptance. Throughput is one operation per
// cycle while the receiver does not stall: every cell compares against the new
// value and moves one place in the same cycle; chain length does not affect the rate.
// The result register frees as it is read, so a new operation is accepted
// in the cycle the previous result is taken.
// When the receiver stalls, the result is held and s_tready stays low until
// m_tready returns. Reset empties the queue and clears m_tvalid; the cell
// contents are not reset because only occupied cells are ever read.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit
#(
    parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY,
    parameter int CNT_W    = $clog2(CAPACITY + 1),
    parameter int OUT_W    = ((spq_pkg::STATUS_W + spq_pkg::VALUE_W + CNT_W + 7) / 8) * 8
)
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire [spq_pkg::VALUE_W-1:0]   s_tdata,   // [31:0] value
    input  wire                          s_tuser,   // [0] operation
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [OUT_W-1:0]             m_tdata    // status, removed_value, occupancy
);

    localparam int VW = spq_pkg::VALUE_W;

    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [OUT_W-1:0]              out_data_reg;
    logic [OUT_W-1:0]              out_data_next;

    logic                          accept;
    logic                          is_full;
    logic                          is_empty;
    spq_pkg::status_t              status;
    logic signed [VW-1:0]          removed;
    spq_pkg::cell_cmd_t            cmd;

    logic [CAPACITY-1:0]           occupied;
    logic [CAPACITY-1:0]           cell_gt;
    logic signed [VW-1:0]          cell_value [CAPACITY];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    always_comb
    begin
        status        = spq_pkg::ST_OK;
        removed       = '0;
        count_next    = count_reg;
        cmd.insert_en = 1'b0;
        cmd.remove_en = 1'b0;
        cmd.new_value = $signed(s_tdata);
        if (accept)
        begin
            case (spq_pkg::op_t'(s_tuser))
                spq_pkg::OP_INSERT:
                begin
                    if (is_full)
                    begin
                        status = spq_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd.insert_en = 1'b1;
                        count_next    = count_reg + 1'b1;
                    end
                end
                spq_pkg::OP_REMOVE:
                begin
                    if (is_empty)
                    begin
                        status = spq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        cmd.remove_en = 1'b1;
                        removed       = cell_value[0];
                        count_next    = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    status = spq_pkg::ST_OK;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_data_next  = OUT_W'({count_next, removed, status});
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic                 left_gt;
            logic signed [VW-1:0] left_value;
            logic signed [VW-1:0] right_value;

            assign occupied[gi] = (count_reg > CNT_W'(gi));

            if (gi == 0)
            begin : g_first
                assign left_gt    = 1'b0;
                assign left_value = cmd.new_value;
            end
            else
            begin : g_mid
                assign left_gt    = cell_gt[gi-1];
                assign left_value = cell_value[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_value = cell_value[gi];
            end
            else
            begin : g_inner
                assign right_value = cell_value[gi+1];
            end

            spq_cell u_cell
            (
                .clk         (clk),
                .cmd         (cmd),
                .occupied    (occupied[gi]),
                .left_gt     (left_gt),
                .left_value  (left_value),
                .right_value (right_value),
                .value       (cell_value[gi]),
                .gt          (cell_gt[gi])
            );
        end
    endgenerate

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire

[rtl/spq_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue port checker
// Watches the ports of the top level and checks handshake and result
// consistency over time.
// ----------------------------------------------------------------------------
module spq_checker
#(
    parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY,
    parameter int CNT_W    = $clog2(CAPACITY + 1),
    parameter int OUT_W    = ((spq_pkg::STATUS_W + spq_pkg::VALUE_W + CNT_W + 7) / 8) * 8
)
(
    input wire                        clk,
    input wire                        rst_n,
    input wire                        s_tvalid,
    input wire                        s_tready,
    input wire                        m_tvalid,
    input wire                        m_tready,
    input wire [OUT_W-1:0]            m_tdata
);

    localparam int VW = spq_pkg::VALUE_W;
    localparam int SW = spq_pkg::STATUS_W;

    logic [SW-1:0]    res_status;
    logic [VW-1:0]    res_removed;
    logic [CNT_W-1:0] res_occupancy;

    assign res_status    = m_tdata[SW-1:0];
    assign res_removed   = m_tdata[SW+VW-1:SW];
    assign res_occupancy = m_tdata[SW+VW+CNT_W-1:SW+VW];

    // A stalled result is held with its data.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // No new transaction is taken while a result waits.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while result stalled");

    // Every accepted transaction gives a result in the next cycle.
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted transaction gave no result");

    // A dropped insert means the queue was full; an ignored remove, empty.
    a_status_occ: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |->
            (res_status != spq_pkg::ST_FULL || res_occupancy == CNT_W'(CAPACITY)) &&
            (res_status != spq_pkg::ST_EMPTY || res_occupancy == '0) &&
            (res_occupancy <= CNT_W'(CAPACITY)))
        else $error("status and occupancy disagree");

    // Only a successful remove returns a nonzero value.
    a_removed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (res_removed != '0) |-> res_status == spq_pkg::ST_OK)
        else $error("value returned with a failure status");

endmodule

bind sorted_priority_queue_unit spq_checker
#(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W),
    .OUT_W    (OUT_W)
)
u_spq_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue unit testbench
// Drives insert and remove-smallest operations through the slave stream,
// predicts every result with its own ordered store and checks each master
// transaction field by field, under several patterns of sender idling and
// receiver back-pressure.
// ----------------------------------------------------------------------------
module tb;

    localparam int QUEUE_DEPTH = spq_pkg::DEFAULT_CAPACITY;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int RESULT_W    =
        ((spq_pkg::STATUS_W + spq_pkg::VALUE_W + COUNT_W + 7) / 8) * 8;
    localparam int PHASE_ITEMS = 400;

    typedef logic signed [spq_pkg::VALUE_W-1:0] value_t;

    typedef struct {
        spq_pkg::status_t     status;
        value_t               removed;
        logic [COUNT_W-1:0]   occupancy;
    } queue_result_t;

    // Holds its own copy of the queue contents and the results still owed.
    class result_scoreboard;
        value_t         ordered_values[$];
        queue_result_t  owed_results[$];
        int             errors;

        function new();
            errors = 0;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        function void note_operation(spq_pkg::op_t op, value_t val);
            queue_result_t r;
            int            pos;
            r.status  = spq_pkg::ST_OK;
            r.removed = '0;
            if (op == spq_pkg::OP_INSERT)
            begin
                if (ordered_values.size() >= QUEUE_DEPTH)
                begin
                    r.status = spq_pkg::ST_FULL;
                end
                else
                begin
                    // Goes behind every stored value that is smaller or equal.
                    pos = 0;
                    while (pos < ordered_values.size() && ordered_values[pos] <= val)
                        pos++;
                    ordered_values.insert(pos, val);
                end
            end
            else
            begin
                if (ordered_values.size() == 0)
                    r.status = spq_pkg::ST_EMPTY;
                else
                    r.removed = ordered_values.pop_front();
            end
            r.occupancy = COUNT_W'(ordered_values.size());
            owed_results.push_back(r);
        endfunction

        function void check_result(logic [RESULT_W-1:0] data);
            queue_result_t                r;
            logic [spq_pkg::STATUS_W-1:0] got_status;
            value_t                       got_removed;
            logic [COUNT_W-1:0]           got_occupancy;
            got_status    = data[spq_pkg::STATUS_W-1:0];
            got_removed   = data[spq_pkg::STATUS_W +: spq_pkg::VALUE_W];
            got_occupancy = data[spq_pkg::STATUS_W+spq_pkg::VALUE_W +: COUNT_W];
            if (owed_results.size() == 0)
            begin
                $error("result transaction with no operation outstanding: %h", data);
                errors++;
                return;
            end
            r = owed_results.pop_front();
            if (got_status !== r.status)
            begin
                $error("status mismatch: expected %0d, actual %0d", r.status, got_status);
                errors++;
            end
            if (got_removed !== r.removed)
            begin
                $error("removed_value mismatch: expected %0d, actual %0d",
                       r.removed, got_removed);
                errors++;
            end
            if (got_occupancy !== r.occupancy)
            begin
                $error("occupancy mismatch: expected %0d, actual %0d",
                       r.occupancy, got_occupancy);
                errors++;
            end
        endfunction
    endclass

    logic                          clk      = 1'b0;
    logic                          rst_n    = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [spq_pkg::VALUE_W-1:0]   s_tdata  = '0;
    logic                          s_tuser  = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [RESULT_W-1:0]           m_tdata;

    result_scoreboard sb;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    bit   long_hold_req  = 1'b0;

    sorted_priority_queue_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Transactions on both channels are taken from the values held before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_operation(spq_pkg::op_t'(s_tuser), value_t'(s_tdata));
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                hold_left     = 80;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Called just after a rising edge; returns just after the edge that accepts the item.
    task automatic send_item(spq_pkg::op_t op, value_t val);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= val;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    function automatic value_t random_value();
        case ($urandom_range(0, 3))
            0: return value_t'($signed($urandom_range(0, 15)) - 8);
            1: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return value_t'($urandom);
        endcase
    endfunction

    initial
    begin : stimulus
        int            insert_pct;
        int            phase;
        int            i;
        spq_pkg::op_t  op;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Remove from an empty queue, then the value extremes and a run of equal values.
        send_item(spq_pkg::OP_REMOVE, 32'sd0);
        send_item(spq_pkg::OP_INSERT, 32'sh7FFFFFFF);
        send_item(spq_pkg::OP_INSERT, 32'sh80000000);
        send_item(spq_pkg::OP_INSERT, 32'sd0);
        send_item(spq_pkg::OP_INSERT, -32'sd1);
        send_item(spq_pkg::OP_INSERT, 32'sd5);
        send_item(spq_pkg::OP_INSERT, 32'sd5);
        send_item(spq_pkg::OP_INSERT, 32'sd5);
        send_item(spq_pkg::OP_REMOVE, 32'sh7FFFFFFF);
        send_item(spq_pkg::OP_REMOVE, 32'sd0);
        // Fill to capacity, then try one insert too many.
        for (i = 0; i < 11; i++)
            send_item(spq_pkg::OP_INSERT, value_t'($signed(i) * 3 - 12));
        send_item(spq_pkg::OP_INSERT, 32'sd1);
        for (i = 0; i < 4; i++)
            send_item(spq_pkg::OP_REMOVE, 32'sd0);
        wait_drained();

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 71;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 71;
                end
                default:
                begin
                    send_idle_pct  = 33;
                    recv_stall_pct = 33;
                end
            endcase
            insert_pct = 50;
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                // Swing the mix so the queue keeps reaching both full and empty.
                if (i % 32 == 0)
                    case ($urandom_range(0, 2))
                        0: insert_pct = 15;
                        1: insert_pct = 50;
                        default: insert_pct = 85;
                    endcase
                if (phase == 0 && i == 100)
                    long_hold_req = 1'b1;
                op = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::OP_INSERT
                                                          : spq_pkg::OP_REMOVE;
                send_item(op, random_value());
            end
            wait_drained();
        end

        recv_stall_pct = 0;
        repeat (5) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d results never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule

[sorted_priority_queue_unit.f]
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_unit.sv
rtl/spq_checker.sv
tb/tb.sv
